FILE: src/assert_macros.svh
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: src/htmlent_pkg.sv
// ----------------------------------------------------------------------------
// htmlent_pkg
// types, constants and helpers for the html character reference decoder
// ----------------------------------------------------------------------------
package htmlent_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned ACC_W = 25;
  localparam int unsigned POS_W = 3;

  localparam logic [CP_W-1:0]  CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0]  CP_MAX_1B  = 21'h00007F;
  localparam logic [CP_W-1:0]  CP_MAX_2B  = 21'h0007FF;
  localparam logic [CP_W-1:0]  CP_MAX_3B  = 21'h00FFFF;
  localparam logic [POS_W-1:0] POS_SAT    = 3'd7;
  localparam logic [POS_W-1:0] HEAD_DEPTH = 3'd4;

  localparam logic [7:0] LEAD_2B = 8'hC0;
  localparam logic [7:0] LEAD_3B = 8'hE0;
  localparam logic [7:0] LEAD_4B = 8'hF0;
  localparam logic [7:0] CONT_B  = 8'h80;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;

  localparam logic [23:0] NAME_AMP  = "amp";
  localparam logic [15:0] NAME_LT   = "lt";
  localparam logic [15:0] NAME_GT   = "gt";
  localparam logic [31:0] NAME_QUOT = "quot";
  localparam logic [31:0] NAME_APOS = "apos";

  localparam logic [2:0] CNT_NONE = 3'd0;
  localparam logic [2:0] CNT_1    = 3'd1;
  localparam logic [2:0] CNT_2    = 3'd2;
  localparam logic [2:0] CNT_3    = 3'd3;
  localparam logic [2:0] CNT_4    = 3'd4;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_DEC   = 2'd1,
    MODE_HEX   = 2'd2,
    MODE_NAMED = 2'd3
  } ref_mode_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    ref_mode_t        mode;
    logic [POS_W-1:0] position;
    logic             failed;
    logic [3:0][7:0]  head;
  } name_state_t;

  typedef struct packed {
    logic            ok;
    logic [2:0]      count;
    logic [3:0][7:0] bytes;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_decode(input logic [7:0] b, input logic hex);
    digit_t d;
    d = '0;
    if (b >= CH_0 && b <= CH_9) begin
      d.ok  = 1'b1;
      d.val = 4'(b - CH_0);
    end else if (hex && b >= CH_LA && b <= CH_LF) begin
      d.ok  = 1'b1;
      d.val = 4'(b - CH_LA + 8'd10);
    end else if (hex && b >= CH_UA && b <= CH_UF) begin
      d.ok  = 1'b1;
      d.val = 4'(b - CH_UA + 8'd10);
    end
    return d;
  endfunction

endpackage

FILE: src/htmlent_accum.sv
// ----------------------------------------------------------------------------
// htmlent_accum
// name state registers and the per-byte update of mode, code point and head
// ----------------------------------------------------------------------------
module htmlent_accum (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  logic                      clr,
  input  logic [7:0]                name_byte,
  output htmlent_pkg::name_state_t  st_nxt
);

  logic [htmlent_pkg::CP_W-1:0]  cp_r;
  htmlent_pkg::ref_mode_t        mode_r;
  logic [htmlent_pkg::POS_W-1:0] pos_r;
  logic                          failed_r;
  logic [3:0][7:0]               head_r;

  logic [htmlent_pkg::ACC_W-1:0] acc;
  htmlent_pkg::digit_t           dig;
  logic                          is_hex;

  always_comb begin
    is_hex = (mode_r == htmlent_pkg::MODE_HEX);
    dig    = htmlent_pkg::digit_decode(name_byte, is_hex);
    if (is_hex) begin
      acc = {cp_r, 4'b0} + htmlent_pkg::ACC_W'(dig.val);
    end else begin
      acc = {1'b0, cp_r, 3'b0} + {3'b0, cp_r, 1'b0} + htmlent_pkg::ACC_W'(dig.val);
    end
  end

  always_comb begin
    st_nxt.code_point = cp_r;
    st_nxt.mode       = mode_r;
    st_nxt.failed     = failed_r;
    st_nxt.head       = head_r;
    if (pos_r == '0) begin
      if (name_byte == htmlent_pkg::CH_HASH) begin
        st_nxt.mode = htmlent_pkg::MODE_DEC;
      end else begin
        st_nxt.mode    = htmlent_pkg::MODE_NAMED;
        st_nxt.head[0] = name_byte;
      end
    end else if (mode_r == htmlent_pkg::MODE_NAMED) begin
      if (pos_r < htmlent_pkg::HEAD_DEPTH) begin
        st_nxt.head[pos_r[1:0]] = name_byte;
      end else begin
        st_nxt.failed = 1'b1;
      end
    end else if (mode_r == htmlent_pkg::MODE_DEC && pos_r == 3'd1 &&
                 (name_byte == htmlent_pkg::CH_LX || name_byte == htmlent_pkg::CH_UX)) begin
      st_nxt.mode = htmlent_pkg::MODE_HEX;
    end else if (!failed_r) begin
      if (!dig.ok) begin
        st_nxt.failed = 1'b1;
      end else if (acc > htmlent_pkg::ACC_W'(htmlent_pkg::CP_MAX)) begin
        st_nxt.failed = 1'b1;
      end else begin
        st_nxt.code_point = acc[htmlent_pkg::CP_W-1:0];
      end
    end
    st_nxt.position = (pos_r == htmlent_pkg::POS_SAT) ? pos_r : pos_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r     <= '0;
      mode_r   <= htmlent_pkg::MODE_NONE;
      pos_r    <= '0;
      failed_r <= 1'b0;
    end else if (upd) begin
      if (clr) begin
        cp_r     <= '0;
        mode_r   <= htmlent_pkg::MODE_NONE;
        pos_r    <= '0;
        failed_r <= 1'b0;
      end else begin
        cp_r     <= st_nxt.code_point;
        mode_r   <= st_nxt.mode;
        pos_r    <= st_nxt.position;
        failed_r <= st_nxt.failed;
      end
    end
  end

  // head bytes are only read at positions written in the current name
  always_ff @(posedge clk) begin
    if (upd) begin
      head_r <= st_nxt.head;
    end
  end

endmodule

FILE: src/htmlent_encode.sv
// ----------------------------------------------------------------------------
// htmlent_encode
// final check of a name and utf-8 encoding of the code point
// ----------------------------------------------------------------------------
module htmlent_encode (
  input  htmlent_pkg::name_state_t st,
  output htmlent_pkg::result_t     res
);

  logic [htmlent_pkg::CP_W-1:0] cp;
  logic                         num_ok;

  always_comb begin
    cp     = st.code_point;
    num_ok = 1'b0;
    res    = '0;
    if (!st.failed) begin
      case (st.mode)
        htmlent_pkg::MODE_NAMED: begin
          if (st.position == 3'd3 && {st.head[0], st.head[1], st.head[2]} ==
              htmlent_pkg::NAME_AMP) begin
            res.bytes[0] = htmlent_pkg::CH_AMP;
            res.count    = htmlent_pkg::CNT_1;
          end else if (st.position == 3'd2 && {st.head[0], st.head[1]} ==
                       htmlent_pkg::NAME_LT) begin
            res.bytes[0] = htmlent_pkg::CH_LT;
            res.count    = htmlent_pkg::CNT_1;
          end else if (st.position == 3'd2 && {st.head[0], st.head[1]} ==
                       htmlent_pkg::NAME_GT) begin
            res.bytes[0] = htmlent_pkg::CH_GT;
            res.count    = htmlent_pkg::CNT_1;
          end else if (st.position == 3'd4 && {st.head[0], st.head[1], st.head[2],
                       st.head[3]} == htmlent_pkg::NAME_QUOT) begin
            res.bytes[0] = htmlent_pkg::CH_QUOT;
            res.count    = htmlent_pkg::CNT_1;
          end else if (st.position == 3'd4 && {st.head[0], st.head[1], st.head[2],
                       st.head[3]} == htmlent_pkg::NAME_APOS) begin
            res.bytes[0] = htmlent_pkg::CH_APOS;
            res.count    = htmlent_pkg::CNT_1;
          end
        end
        htmlent_pkg::MODE_DEC: num_ok = (st.position > 3'd1);
        htmlent_pkg::MODE_HEX: num_ok = (st.position > 3'd2);
        default:               num_ok = 1'b0;
      endcase
    end

    if (num_ok) begin
      if (cp <= htmlent_pkg::CP_MAX_1B) begin
        res.bytes[0] = cp[7:0];
        res.count    = htmlent_pkg::CNT_1;
      end else if (cp <= htmlent_pkg::CP_MAX_2B) begin
        res.bytes[0] = htmlent_pkg::LEAD_2B | {3'b0, cp[10:6]};
        res.bytes[1] = htmlent_pkg::CONT_B  | {2'b0, cp[5:0]};
        res.count    = htmlent_pkg::CNT_2;
      end else if (cp <= htmlent_pkg::CP_MAX_3B) begin
        res.bytes[0] = htmlent_pkg::LEAD_3B | {4'b0, cp[15:12]};
        res.bytes[1] = htmlent_pkg::CONT_B  | {2'b0, cp[11:6]};
        res.bytes[2] = htmlent_pkg::CONT_B  | {2'b0, cp[5:0]};
        res.count    = htmlent_pkg::CNT_3;
      end else if (cp <= htmlent_pkg::CP_MAX) begin
        res.bytes[0] = htmlent_pkg::LEAD_4B | {5'b0, cp[20:18]};
        res.bytes[1] = htmlent_pkg::CONT_B  | {2'b0, cp[17:12]};
        res.bytes[2] = htmlent_pkg::CONT_B  | {2'b0, cp[11:6]};
        res.bytes[3] = htmlent_pkg::CONT_B  | {2'b0, cp[5:0]};
        res.count    = htmlent_pkg::CNT_4;
      end
    end
    res.ok = (res.count != htmlent_pkg::CNT_NONE);
  end

endmodule

FILE: src/html_entity_to_utf8_decoder_top.sv
// ----------------------------------------------------------------------------
// html_entity_to_utf8_decoder_top
// decodes an html character reference name, one byte per request, to utf-8
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       sink       in_valid/in_stall  name_byte, is_last, name_empty
//  out_      source     out_valid/out_stall ok, byte_count, out_byte0..3
//
//  one request accepted per cycle when the result side keeps up
//  a request is taken into an input register, and from there the name state is
//  updated and, for a last or empty request, the result register is loaded
//  synchronous active-low reset clears the pipe and the name state
//  a held result stalls only a last or empty request waiting behind it
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module html_entity_to_utf8_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_name_byte,
  input  logic       in_is_last,
  input  logic       in_name_empty,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_ok,
  output logic [2:0] out_byte_count,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3
);

  // input register
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_empty_r;

  // result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  htmlent_pkg::result_t out_res_r;

  htmlent_pkg::name_state_t st_nxt;
  htmlent_pkg::result_t     enc_res;

  logic s1_emits;
  logic out_free;
  logic s1_go;
  logic in_fire;

  // a request that ends a name needs room in the result register
  assign s1_emits = s1_last_r | s1_empty_r;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_emits || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_name_byte;
      s1_last_r  <= in_is_last;
      s1_empty_r <= in_name_empty;
    end
  end

  // name state: cleared after every result, and by an empty name
  htmlent_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (s1_go),
    .clr       (s1_emits),
    .name_byte (s1_byte_r),
    .st_nxt    (st_nxt)
  );

  // encoder sees the state including the last byte
  htmlent_encode u_encode (
    .st  (st_nxt),
    .res (enc_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go && s1_emits) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // empty name always fails, whatever was in progress
  always_ff @(posedge clk) begin
    if (s1_go && s1_emits) begin
      out_res_r <= s1_empty_r ? '0 : enc_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_res_r.ok;
  assign out_byte_count = out_res_r.count;
  assign out_byte0      = out_res_r.bytes[0];
  assign out_byte1      = out_res_r.bytes[1];
  assign out_byte2      = out_res_r.bytes[2];
  assign out_byte3      = out_res_r.bytes[3];

  // a new result appears only from a request that ends a name
  `ASSERT_CLK(a_result_src, $rose(out_valid_r) |-> $past(s1_valid_r && s1_emits), "result without last or empty request")
  // failure carries no bytes
  `ASSERT_CLK(a_fail_zero, out_valid_r && !out_res_r.ok |-> out_res_r.count == htmlent_pkg::CNT_NONE && out_res_r.bytes == '0, "failed result with data")
  // backpressure only with a request held in the input register
  `ASSERT_CLK(a_stall_src, in_stall |-> s1_valid_r && s1_emits && out_valid_r, "stall without held request")
  // never more than four bytes
  `ASSERT_NEVER(a_count_max, out_valid_r && out_res_r.count > htmlent_pkg::CNT_4, "byte count above four")

endmodule

FILE: tb/html_entity_to_utf8_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// html_entity_to_utf8_decoder_top_tb
// self-checking bench for the html character reference decoder: entity names
// go in one byte per request, a local decoder predicts each utf-8 result and
// every result is checked field by field, with random gaps on the request
// channel and random stalls on the result
// channel
module html_entity_to_utf8_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import htmlent_pkg::*;

  // generous bound for ~1650 requests, each with random gaps and stalls
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef logic [7:0] byte_q_t[$];
  typedef enum int {GEN_NAMED, GEN_NUMERIC, GEN_BROKEN} name_gen_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_name_byte = 8'h00;
  logic       in_is_last = 1'b0;
  logic       in_name_empty = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_ok;
  logic [2:0] out_byte_count;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;

  html_entity_to_utf8_decoder_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_name_byte  (in_name_byte),
    .in_is_last    (in_is_last),
    .in_name_empty (in_name_empty),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_byte_count(out_byte_count),
    .out_byte0     (out_byte0),
    .out_byte1     (out_byte1),
    .out_byte2     (out_byte2),
    .out_byte3     (out_byte3)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // local copy of the name state, as the decoder should hold it
  logic [CP_W-1:0]  name_cp = '0;
  ref_mode_t        name_mode = MODE_NONE;
  logic [POS_W-1:0] name_pos = '0;
  bit               name_failed = 1'b0;
  logic [7:0]       name_head [4];

  // utf-8 results still owed by the decoder, oldest first
  result_t pending_utf8[$];

  int  mismatch_count = 0;
  int  bytes_sent = 0;
  int  cycle_count = 0;
  bit  quiet_mode = 1'b0;   // no gaps and no stalls while set
  int  stall_left = 0;

  string       known_names [5] = '{"amp", "lt", "gt", "quot", "apos"};
  // code points at the utf-8 length boundaries, surrogates and the top of range
  int unsigned cp_edges [13] = '{'h0, 'h1, 'h7F, 'h80, 'h7FF, 'h800, 'hD800,
                                 'hDFFF, 'hFFFF, 'h10000, 'h10FFFF, 'h110000,
                                 'h1FFFFF};

  function automatic void clear_name_state();
    name_cp     = '0;
    name_mode   = MODE_NONE;
    name_pos    = '0;
    name_failed = 1'b0;
    name_head   = '{default: 8'h00};
  endfunction

  // advance the name state by one accepted request, queue a result if one is due
  function automatic void decode_entity_byte(input logic [7:0] b, input bit last,
                                             input bit empty);
    result_t     r;
    int          dig;
    bit          is_hex;
    int unsigned acc;
    int unsigned cp;
    logic [2:0]  len;
    r = '0;
    if (empty) begin
      // empty name drops whatever was in progress
      clear_name_state();
      pending_utf8.push_back(r);
      return;
    end
    if (name_pos == 0) begin
      if (b == CH_HASH) begin
        name_mode = MODE_DEC;
      end else begin
        name_mode    = MODE_NAMED;
        name_head[0] = b;
      end
    end else if (name_mode == MODE_NAMED) begin
      if (name_pos < 4) name_head[name_pos[1:0]] = b;
      else name_failed = 1'b1;
    end else if (name_mode == MODE_DEC && name_pos == 1 && (b == CH_LX || b == CH_UX)) begin
      name_mode = MODE_HEX;
    end else if (!name_failed) begin
      is_hex = (name_mode == MODE_HEX);
      dig = -1;
      if (b >= CH_0 && b <= CH_9) dig = int'(b) - int'(CH_0);
      else if (is_hex && b >= CH_LA && b <= CH_LF) dig = int'(b) - int'(CH_LA) + 10;
      else if (is_hex && b >= CH_UA && b <= CH_UF) dig = int'(b) - int'(CH_UA) + 10;
      if (dig < 0) begin
        name_failed = 1'b1;
      end else begin
        acc = 32'(name_cp) * (is_hex ? 32'd16 : 32'd10) + 32'(dig);
        if (acc > 32'(CP_MAX)) name_failed = 1'b1;
        else name_cp = acc[CP_W-1:0];
      end
    end
    name_pos = (name_pos < POS_SAT) ? name_pos + 3'd1 : POS_SAT;
    if (!last) return;

    len = name_pos;
    cp  = 32'(name_cp);
    if (!name_failed) begin
      if (name_mode == MODE_NAMED) begin
        if (len == 3 && {name_head[0], name_head[1], name_head[2]} == NAME_AMP) begin
          r.count = CNT_1; r.bytes[0] = CH_AMP;
        end else if (len == 2 && {name_head[0], name_head[1]} == NAME_LT) begin
          r.count = CNT_1; r.bytes[0] = CH_LT;
        end else if (len == 2 && {name_head[0], name_head[1]} == NAME_GT) begin
          r.count = CNT_1; r.bytes[0] = CH_GT;
        end else if (len == 4 && {name_head[0], name_head[1], name_head[2],
                                  name_head[3]} == NAME_QUOT) begin
          r.count = CNT_1; r.bytes[0] = CH_QUOT;
        end else if (len == 4 && {name_head[0], name_head[1], name_head[2],
                                  name_head[3]} == NAME_APOS) begin
          r.count = CNT_1; r.bytes[0] = CH_APOS;
        end
      end else if ((name_mode == MODE_DEC && len > 1) || (name_mode == MODE_HEX && len > 2)) begin
        if (cp <= 32'(CP_MAX_1B)) begin
          r.count    = CNT_1;
          r.bytes[0] = 8'(cp);
        end else if (cp <= 32'(CP_MAX_2B)) begin
          r.count    = CNT_2;
          r.bytes[0] = 8'(LEAD_2B | (cp >> 6));
          r.bytes[1] = 8'(CONT_B | (cp & 'h3F));
        end else if (cp <= 32'(CP_MAX_3B)) begin
          r.count    = CNT_3;
          r.bytes[0] = 8'(LEAD_3B | (cp >> 12));
          r.bytes[1] = 8'(CONT_B | ((cp >> 6) & 'h3F));
          r.bytes[2] = 8'(CONT_B | (cp & 'h3F));
        end else begin
          r.count    = CNT_4;
          r.bytes[0] = 8'(LEAD_4B | (cp >> 18));
          r.bytes[1] = 8'(CONT_B | ((cp >> 12) & 'h3F));
          r.bytes[2] = 8'(CONT_B | ((cp >> 6) & 'h3F));
          r.bytes[3] = 8'(CONT_B | (cp & 'h3F));
        end
      end
    end
    r.ok = (r.count != CNT_NONE);
    pending_utf8.push_back(r);
    clear_name_state();
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall driven at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      // roll for a new stall, its length taken from pick_gap
      stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      out_stall  = (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result check: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  result_t    want;
  logic [7:0] got_byte [4];

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_utf8.size() == 0) begin
        $error("result with nothing expected: ok %0d count %0d", out_ok, out_byte_count);
        mismatch_count++;
      end else begin
        want = pending_utf8.pop_front();
        got_byte = '{out_byte0, out_byte1, out_byte2, out_byte3};
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          mismatch_count++;
        end
        if (out_byte_count !== want.count) begin
          $error("byte_count: expected %0d, got %0d", want.count, out_byte_count);
          mismatch_count++;
        end
        for (int k = 0; k < 4; k++) begin
          if (got_byte[k] !== want.bytes[k]) begin
            $error("out_byte%0d: expected %02h, got %02h", k, want.bytes[k], got_byte[k]);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request: optional gap, then hold until accepted, then predict
  task automatic send_request(input logic [7:0] b, input bit last, input bit empty);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_name_byte  = b;
    in_is_last    = last;
    in_name_empty = empty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_entity_byte(b, last, empty);
    bytes_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // a whole name; when cut short, the last byte is left unmarked and an empty
  // request follows, which drops the partial name
  task automatic send_name(input byte_q_t name, input bit cut_short);
    for (int i = 0; i < name.size(); i++)
      send_request(name[i], !cut_short && (i == name.size() - 1), 1'b0);
    if (cut_short) send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_text(input string s);
    send_name(to_bytes(s), 1'b0);
  endtask

  // pause the sender until every owed result has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_utf8.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // known names, sometimes with a flipped case, an extra letter, a missing
  // letter or replaced by random lowercase letters
  function automatic byte_q_t named_text();
    byte_q_t q;
    int      pick;
    q = to_bytes(known_names[$urandom_range(0, 4)]);
    pick = $urandom_range(0, 9);
    if (pick == 6) begin
      q[$urandom_range(0, q.size() - 1)] ^= 8'h20;
    end else if (pick == 7) begin
      q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end else if (pick == 8) begin
      void'(q.pop_back());
    end else if (pick == 9) begin
      q.delete();
      repeat ($urandom_range(1, 7)) q.push_back(8'($urandom_range(8'h61, 8'h7A)));
    end
    return q;
  endfunction

  // well-formed numeric reference, decimal or hex, mixed-case digits and
  // occasional leading zeros
  function automatic byte_q_t numeric_text();
    byte_q_t     q;
    int unsigned cp;
    bit          hex;
    string       digits;
    logic [7:0]  ch;
    case ($urandom_range(0, 3))
      0:       cp = cp_edges[$urandom_range(0, 12)];
      1:       cp = $urandom_range(0, 'h7FF);
      2:       cp = $urandom_range(0, 'h10FFFF);
      default: cp = $urandom_range(0, 'h1FFFFF);
    endcase
    hex = 1'($urandom_range(0, 1));
    digits = hex ? $sformatf("%0h", cp) : $sformatf("%0d", cp);
    q.push_back(CH_HASH);
    if (hex) q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) q.push_back(CH_0);
    for (int i = 0; i < digits.len(); i++) begin
      ch = digits[i];
      if (ch >= CH_LA && $urandom_range(0, 1) == 1) ch = ch - 8'h20;
      q.push_back(ch);
    end
    return q;
  endfunction

  // noise and malformed names
  function automatic byte_q_t broken_text();
    byte_q_t q;
    case ($urandom_range(0, 4))
      0: begin
        repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      end
      1: begin
        q = numeric_text();
        q[$urandom_range(1, q.size() - 1)] = 8'($urandom_range(0, 255));
      end
      2: begin
        // 'x' past the second byte
        q = numeric_text();
        q.insert($urandom_range(2, q.size()), CH_LX);
      end
      3: begin
        // bare prefix or long digit runs
        q.push_back(CH_HASH);
        if ($urandom_range(0, 1) == 1) q.push_back(CH_LX);
        repeat ($urandom_range(0, 10)) q.push_back(CH_0 + 8'($urandom_range(0, 9)));
      end
      default: begin
        q = named_text();
        repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
    endcase
    return q;
  endfunction

  task automatic run_random(input name_gen_t kind, input int n_bytes);
    int      stop_at;
    int      names;
    byte_q_t q;
    bit      cut;
    stop_at = bytes_sent + n_bytes;
    names = 0;
    while (bytes_sent < stop_at) begin
      case (kind)
        GEN_NAMED:   q = named_text();
        GEN_NUMERIC: q = numeric_text();
        default:     q = broken_text();
      endcase
      // now and then a lone empty request or a name cut off by one
      if ($urandom_range(0, 19) == 0) q.delete();
      cut = (q.size() == 0) || ($urandom_range(0, 14) == 0);
      send_name(q, cut);
      names++;
      // switch between idling and back-to-back stretches
      if (names % 64 == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
    quiet_mode = 1'b0;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // named references: two known ones, unknown names with byte extremes
  task automatic test_named_refs();
    send_text("lt");
    send_text("amp");
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    wait_drained();
  endtask

  // numeric references: lone '#', lone '#x', 'x' too late, overflow, one digit
  task automatic test_numeric_refs();
    send_text("#");
    send_text("#x");
    send_text("#1x");
    send_text("#x110000");
    send_text("#9");
    wait_drained();
  endtask

  // empty name alone, then empty in the middle of a name
  task automatic test_empty_name();
    send_request(8'hFF, 1'b1, 1'b1);
    send_name(to_bytes("#1"), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_named();
    run_random(GEN_NAMED, 400);
  endtask

  task automatic test_random_numeric();
    run_random(GEN_NUMERIC, 800);
  endtask

  task automatic test_random_broken();
    run_random(GEN_BROKEN, 400);
  endtask

  initial begin
    clear_name_state();
    // reset held from the start, released at a falling edge
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_named_refs();
    test_numeric_refs();
    test_empty_name();
    test_random_named();
    test_random_numeric();
    test_random_broken();

    wait_drained();
    // let any stray result show up
    repeat (8) @(posedge clk);
    if (pending_utf8.size() != 0) begin
      $error("%0d results never arrived", pending_utf8.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
